### design/stair_walker_light_tracker_defines.svh
// ----------------------------------------------------------------------------
// Stair walker light tracker assertion macros
// Shared check forms for the tracker's concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef STAIR_WALKER_LIGHT_TRACKER_DEFINES_SVH
`define STAIR_WALKER_LIGHT_TRACKER_DEFINES_SVH

// Property holds at every edge out of reset
`define SWLT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent
`define SWLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/swlt_pkg.sv
// ----------------------------------------------------------------------------
// Stair walker light tracker package
// Field widths and the word that travels along the walker cell chain.
// ----------------------------------------------------------------------------
package swlt_pkg;

  localparam int TIME_W    = 32;
  localparam int START_W   = 4;
  localparam int LIT_W     = 16;
  localparam int LIT_IDX_W = 4;

  // Frame word handed from cell to cell
  typedef struct packed {
    logic                vld;     // word present at this cell
    logic                req;     // frame carries a new walker
    logic                stored;  // new walker already placed upstream
    logic                down;    // new walker direction
    logic [START_W-1:0]  start;   // new walker start stair
    logic [TIME_W-1:0]   delay;   // new walker per-stair delay
    logic [TIME_W-1:0]   now;     // frame tick time
    logic [LIT_W-1:0]    lit;     // stairs lit so far
  } swlt_word_t;

endpackage

### design/swlt_cell.sv
// ----------------------------------------------------------------------------
// Stair walker cell
// Holds one walker slot. When the frame word passes, it takes the new walker
// if the slot is free or finished and none upstream took it, lights its stair
// and steps once if its delay has run out.
// ----------------------------------------------------------------------------
module swlt_cell
  import swlt_pkg::*;
#(
  parameter int NUM_STAIRS = 16,
  parameter int POS_W      = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  input  swlt_word_t word_i,
  output swlt_word_t word_o
);

  localparam logic signed [POS_W-1:0] STAIRS_P = POS_W'(NUM_STAIRS);
  localparam logic signed [POS_W-1:0] LIT_LIM  = POS_W'(LIT_W);
  localparam logic signed [POS_W-1:0] STEP_ONE = POS_W'(1);
  localparam logic signed [POS_W-1:0] POS_ZERO = '0;

  // Walker slot state
  logic                    used_r, used_nxt;
  logic                    down_r;
  logic signed [POS_W-1:0] pos_r, pos_nxt;
  logic [TIME_W-1:0]       delay_r;
  logic [TIME_W-1:0]       last_r, last_nxt;
  swlt_word_t              word_r, word_nxt;

  logic                    finished;
  logic                    take;
  logic                    eff_down;
  logic signed [POS_W-1:0] eff_pos;
  logic [TIME_W-1:0]       eff_delay;
  logic [TIME_W-1:0]       eff_last;
  logic                    eff_fin;
  logic                    active;
  logic                    on_mask;
  logic [TIME_W-1:0]       elapsed;
  logic                    step;
  logic [LIT_W-1:0]        lit_bit;

  // Slot claim: first free or finished slot along the chain
  always_comb begin
    finished = down_r ? (pos_r < POS_ZERO) : (pos_r >= STAIRS_P);
    take     = word_i.vld && word_i.req && !word_i.stored && (!used_r || finished);
  end

  // Walker as seen by this frame, after a possible claim
  always_comb begin
    eff_down  = take ? word_i.down : down_r;
    eff_pos   = take ? $signed({{(POS_W-START_W){1'b0}}, word_i.start}) : pos_r;
    eff_delay = take ? word_i.delay : delay_r;
    eff_last  = take ? word_i.now : last_r;
    eff_fin   = eff_down ? (eff_pos < POS_ZERO) : (eff_pos >= STAIRS_P);
    active    = word_i.vld && (used_r || take) && !eff_fin;
  end

  // Light and step
  always_comb begin
    on_mask  = (eff_pos >= POS_ZERO) && (eff_pos < STAIRS_P) && (eff_pos < LIT_LIM);
    lit_bit  = (active && on_mask) ? (LIT_W'(1) << eff_pos[LIT_IDX_W-1:0]) : '0;
    elapsed  = word_i.now - eff_last;
    step     = active && (elapsed > eff_delay);
    used_nxt = used_r || take;
    pos_nxt  = step ? (eff_down ? eff_pos - STEP_ONE : eff_pos + STEP_ONE) : eff_pos;
    last_nxt = step ? word_i.now : eff_last;
  end

  // Word to the next cell
  always_comb begin
    word_nxt        = word_i;
    word_nxt.lit    = word_i.lit | lit_bit;
    word_nxt.stored = word_i.stored || take;
  end

  // Slot control state and outgoing word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= 1'b0;
      word_r.vld <= 1'b0;
    end else begin
      word_r.vld <= word_nxt.vld;
      if (word_i.vld) begin
        used_r <= used_nxt;
      end
    end
    word_r.req    <= word_nxt.req;
    word_r.stored <= word_nxt.stored;
    word_r.down   <= word_nxt.down;
    word_r.start  <= word_nxt.start;
    word_r.delay  <= word_nxt.delay;
    word_r.now    <= word_nxt.now;
    word_r.lit    <= word_nxt.lit;
  end

  // Slot payload
  always_ff @(posedge clk) begin
    if (take) begin
      down_r  <= word_i.down;
      delay_r <= word_i.delay;
    end
    if (word_i.vld) begin
      pos_r  <= pos_nxt;
      last_r <= last_nxt;
    end
  end

  assign word_o = word_r;

endmodule

### design/stair_walker_light_tracker.sv
// ----------------------------------------------------------------------------
// Stair walker light tracker
// Table of walkers on a staircase, one walker per cell in a chain. Each frame
// word runs down the chain, placing a new walker and collecting the lit mask.
//
//   Channel | Ports                                          | Direction
//   --------+------------------------------------------------+----------
//   in      | in_valid/in_ready, opcode, walk_down, start,   | input
//           | step_delay, now                                |
//   out     | out_valid/out_ready, lit_stairs, stored        | output
//
// The first cell loads the frame at the accepting edge; the frame then passes
// through each walker cell in turn, then the done stage and the output word.
// One frame is in the chain at a time; the next is accepted as soon as the
// previous result has moved into the output register, even if it is unread.
// Reset clears all slots to unused; no clearing sweep is needed.
// ----------------------------------------------------------------------------
`include "stair_walker_light_tracker_defines.svh"

module stair_walker_light_tracker
  import swlt_pkg::*;
#(
  parameter int NUM_STAIRS  = 16,
  parameter int MAX_WALKERS = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_opcode,
  input  logic                in_walk_down,
  input  logic [START_W-1:0]  in_start_stair,
  input  logic [TIME_W-1:0]   in_step_delay,
  input  logic [TIME_W-1:0]   in_now,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [LIT_W-1:0]    out_lit_stairs,
  output logic                out_stored
);

  // Position holds start stairs, one beyond the top and one below the bottom
  localparam int POS_SPAN = ((NUM_STAIRS > LIT_W - 1) ? NUM_STAIRS : LIT_W - 1) + 2;
  localparam int POS_W    = $clog2(POS_SPAN) + 1;

  swlt_word_t             chain [MAX_WALKERS+1];
  logic [MAX_WALKERS:0]   chain_vld;
  logic                   in_fire;
  logic                   busy_r;
  logic                   done_vld_r;
  logic [LIT_W-1:0]       done_lit_r;
  logic                   done_stored_r;
  logic                   out_vld_r;
  logic [LIT_W-1:0]       out_lit_r;
  logic                   out_stored_r;
  logic                   move;
  logic                   live_cnt_ok;

  assign in_ready = !busy_r;
  assign in_fire  = in_valid && in_ready;

  // Frame word entering the first cell
  always_comb begin
    chain[0].vld    = in_fire;
    chain[0].req    = in_opcode;
    chain[0].stored = 1'b0;
    chain[0].down   = in_walk_down;
    chain[0].start  = in_start_stair;
    chain[0].delay  = in_step_delay;
    chain[0].now    = in_now;
    chain[0].lit    = '0;
  end

  // Walker cell chain
  for (genvar k = 0; k < MAX_WALKERS; k++) begin : g_cell
    swlt_cell #(
      .NUM_STAIRS (NUM_STAIRS),
      .POS_W      (POS_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .word_i (chain[k]),
      .word_o (chain[k+1])
    );
  end

  for (genvar k = 0; k <= MAX_WALKERS; k++) begin : g_vld
    assign chain_vld[k] = chain[k].vld;
  end

  // Done stage drains into the output word when that is free
  assign move = done_vld_r && (!out_vld_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      done_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        busy_r <= 1'b1;
      end else if (move) begin
        busy_r <= 1'b0;
      end
      if (chain[MAX_WALKERS].vld) begin
        done_vld_r <= 1'b1;
      end else if (move) begin
        done_vld_r <= 1'b0;
      end
      if (move) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chain[MAX_WALKERS].vld) begin
      done_lit_r    <= chain[MAX_WALKERS].lit;
      done_stored_r <= chain[MAX_WALKERS].req && chain[MAX_WALKERS].stored;
    end
    if (move) begin
      out_lit_r    <= done_lit_r;
      out_stored_r <= done_stored_r;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_lit_stairs = out_lit_r;
  assign out_stored     = out_stored_r;

  // Checks
  assign live_cnt_ok = $countones({chain_vld[MAX_WALKERS:1], done_vld_r}) <= 1;

  `SWLT_ASSERT_ALWAYS(a_one_frame, live_cnt_ok, "more than one frame in the chain")
  `SWLT_ASSERT_NEXT(a_enter_chain, in_fire, chain_vld[1], "accepted frame did not enter chain")
  `SWLT_ASSERT_ALWAYS(a_idle_empty, busy_r || (!done_vld_r && chain_vld[MAX_WALKERS:1] == '0),
    "frame in flight while idle")

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// Stair walker light tracker testbench
// Sends frames, some carrying new walkers, through the valid/ready input and
// checks each lit mask and stored flag against a built-in model of the walker
// table. Both sides idle in random bursts. The run opens with a table fill,
// an overflow and a time wrap, then pauses until drained and goes random.
// ----------------------------------------------------------------------------
module tb;
  import swlt_pkg::*;

  localparam int NUM_STAIRS   = 16;
  localparam int MAX_WALKERS  = 20;
  localparam int RANDOM_WORDS = 1925;
  localparam int QUIET_TAIL   = 150;
  localparam int DRAIN_CYCLES = 50;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef enum logic {
    OP_FRAME      = 1'b0,
    OP_ADD_WALKER = 1'b1
  } frame_op_e;

  typedef struct packed {
    frame_op_e           op;
    logic                down;
    logic [START_W-1:0]  start;
    logic [TIME_W-1:0]   delay;
    logic [TIME_W-1:0]   now;
  } frame_t;

  typedef struct packed {
    logic [LIT_W-1:0]    lit;
    logic                stored;
  } lamp_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_opcode = 1'b0;
  logic                in_walk_down = 1'b0;
  logic [START_W-1:0]  in_start_stair = '0;
  logic [TIME_W-1:0]   in_step_delay = '0;
  logic [TIME_W-1:0]   in_now = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [LIT_W-1:0]    out_lit_stairs;
  logic                out_stored;

  stair_walker_light_tracker #(
    .NUM_STAIRS  (NUM_STAIRS),
    .MAX_WALKERS (MAX_WALKERS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_walk_down   (in_walk_down),
    .in_start_stair (in_start_stair),
    .in_step_delay  (in_step_delay),
    .in_now         (in_now),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_lit_stairs (out_lit_stairs),
    .out_stored     (out_stored)
  );

  frame_t   frames_pending[$];
  lamp_t    lamps_due[$];
  frame_t   frame_on_bus;
  int       errors = 0;
  int       cycle_count = 0;
  bit       quiet = 1'b0;

  // Walker table mirror
  logic            walker_is_down [MAX_WALKERS];
  int              walker_pos     [MAX_WALKERS];
  logic [TIME_W-1:0] walker_wait  [MAX_WALKERS];
  logic [TIME_W-1:0] walker_stamp [MAX_WALKERS];
  int              slots_in_use;

  initial begin
    for (int k = 0; k < MAX_WALKERS; k++) begin
      walker_is_down[k] = 1'b0;
      walker_pos[k]     = NUM_STAIRS + 1;
      walker_wait[k]    = '0;
      walker_stamp[k]   = '0;
    end
    slots_in_use = 0;
  end

  function automatic bit walker_done(input int k);
    if (walker_is_down[k])
      return walker_pos[k] < 0;
    return walker_pos[k] >= NUM_STAIRS;
  endfunction

  // One frame: place the new walker, then light and step every active one
  function automatic lamp_t advance_frame(input frame_t f);
    lamp_t             r;
    int                slot;
    int                p;
    logic [TIME_W-1:0] elapsed;
    r = '0;
    if (f.op == OP_ADD_WALKER) begin
      slot = MAX_WALKERS;
      for (int k = 0; k < slots_in_use; k++) begin
        if (slot == MAX_WALKERS && walker_done(k))
          slot = k;
      end
      if (slot == MAX_WALKERS && slots_in_use < MAX_WALKERS) begin
        slot = slots_in_use;
        slots_in_use++;
      end
      if (slot < MAX_WALKERS) begin
        walker_is_down[slot] = f.down;
        walker_pos[slot]     = int'(f.start);
        walker_wait[slot]    = f.delay;
        walker_stamp[slot]   = f.now;
        r.stored             = 1'b1;
      end
    end
    for (int k = 0; k < slots_in_use; k++) begin
      if (!walker_done(k)) begin
        p = walker_pos[k];
        if (p >= 0 && p < NUM_STAIRS && p < LIT_W)
          r.lit[p] = 1'b1;
        elapsed = f.now - walker_stamp[k];
        if (elapsed > walker_wait[k]) begin
          walker_pos[k]   = walker_is_down[k] ? p - 1 : p + 1;
          walker_stamp[k] = f.now;
        end
      end
    end
    return r;
  endfunction

  function automatic frame_t make_frame(input frame_op_e op, input logic down,
                                        input logic [START_W-1:0] start,
                                        input logic [TIME_W-1:0] delay,
                                        input logic [TIME_W-1:0] now);
    frame_t f;
    f.op    = op;
    f.down  = down;
    f.start = start;
    f.delay = delay;
    f.now   = now;
    return f;
  endfunction

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Input driver: pops frames, inserts idle bursts, predicts on acceptance
  int idle_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      idle_left = 0;
    end else begin
      if (in_valid && in_ready)
        lamps_due.push_back(advance_frame(frame_on_bus));
      if (!in_valid || in_ready) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (frames_pending.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          idle_left = $urandom_range(0, 8);
          in_valid  <= 1'b0;
        end else begin
          frame_on_bus = frames_pending.pop_front();
          in_opcode      <= frame_on_bus.op;
          in_walk_down   <= frame_on_bus.down;
          in_start_stair <= frame_on_bus.start;
          in_step_delay  <= frame_on_bus.delay;
          in_now         <= frame_on_bus.now;
          in_valid       <= 1'b1;
        end
      end
    end
  end

  // Output monitor: random stall bursts, compare each word with the oldest prediction
  int stall_left = 0;
  always @(posedge clk) begin
    lamp_t want;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (lamps_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected word lit_stairs=%h stored=%b", $time,
                   out_lit_stairs, out_stored);
        end else begin
          want = lamps_due.pop_front();
          if (out_lit_stairs !== want.lit) begin
            errors++;
            $display("%0t: lit_stairs expected %h actual %h", $time, want.lit,
                     out_lit_stairs);
          end
          if (out_stored !== want.stored) begin
            errors++;
            $display("%0t: stored expected %b actual %b", $time, want.stored,
                     out_stored);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 8);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    logic [TIME_W-1:0] tick;
    int                add_pct;
    logic [TIME_W-1:0] delay;
    frame_op_e         op;

    // Table fill right before the time wrap; slot 1 steps on any tick change
    frames_pending.push_back(make_frame(OP_FRAME, 1'b1, 4'hf, 32'hffff_ffff,
                                        32'hffff_ff00));
    for (int k = 0; k < MAX_WALKERS; k++)
      frames_pending.push_back(make_frame(OP_ADD_WALKER, k[0], START_W'(k * 13),
                                          (k == 1) ? 32'd0 : 32'd50, 32'hffff_ff00));
    // Table full: dropped, frame still lights
    frames_pending.push_back(make_frame(OP_ADD_WALKER, 1'b0, 4'd7, 32'd3,
                                        32'hffff_ff00));
    // Time wraps past zero: every walker steps
    frames_pending.push_back(make_frame(OP_FRAME, 1'b0, 4'd0, 32'd0, 32'h0000_0010));
    // Add with the largest delay while the table is still full
    frames_pending.push_back(make_frame(OP_ADD_WALKER, 1'b0, 4'd15, 32'hffff_ffff,
                                        32'h0000_0010));
    // Frame only with don't-care walker fields all ones
    frames_pending.push_back(make_frame(OP_FRAME, 1'b1, 4'hf, 32'hffff_ffff,
                                        32'hffff_ffff));
    frames_pending.push_back(make_frame(OP_FRAME, 1'b0, 4'd0, 32'd0, 32'd0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Sender holds off until the block has drained
    while (frames_pending.size() != 0 || in_valid || lamps_due.size() != 0)
      @(posedge clk);

    // Random frames: tick mostly creeps forward so walkers climb the whole flight
    tick    = $urandom();
    add_pct = 35;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 100 == 0)
        add_pct = $urandom_range(15, 65);
      if ($urandom_range(0, 99) < 3)
        tick = $urandom();
      else
        tick = tick + $urandom_range(0, 12);
      case ($urandom_range(0, 19))
        0:       delay = $urandom();
        1, 2, 3: delay = $urandom_range(0, 200);
        default: delay = $urandom_range(0, 25);
      endcase
      op = ($urandom_range(0, 99) < add_pct) ? OP_ADD_WALKER : OP_FRAME;
      frames_pending.push_back(make_frame(op, 1'($urandom_range(0, 1)),
                                          START_W'($urandom_range(0, 15)), delay, tick));
    end

    while (frames_pending.size() > QUIET_TAIL)
      @(posedge clk);
    quiet = 1'b1;

    while (frames_pending.size() != 0 || in_valid || lamps_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (lamps_due.size() != 0) begin
      errors++;
      $display("%0t: %0d words never arrived", $time, lamps_due.size());
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/swlt_pkg.sv
design/swlt_cell.sv
design/stair_walker_light_tracker.sv
bench/tb.sv
